@@ design/rx_block_reassembly_assert.svh @@
// Assertion macros for the receive reassembly controller.
// Used by rx_block_reassembly; expects clk_i and rst_ni in scope.
`ifndef RX_BLOCK_REASSEMBLY_ASSERT_SVH
`define RX_BLOCK_REASSEMBLY_ASSERT_SVH

// Consequent holds in the same cycle as the antecedent.
`define RXBR_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define RXBR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/rxbr_pkg.sv @@
// Shared types and constants for the receive reassembly controller.
// No dependencies.
package rxbr_pkg;

  localparam int STACK_DEPTH = 16;
  localparam int ID_BITS     = 8;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(STACK_DEPTH);

  localparam logic [2:0] REASON_FCS_OK   = 3'd0;
  localparam logic [2:0] REASON_FCS_BAD  = 3'd1;
  localparam logic [2:0] REASON_ODD_NYB  = 3'd2;
  localparam logic [2:0] REASON_OVERRUN  = 3'd4;
  localparam logic [2:0] REASON_FRAMING  = 3'd5;

  localparam logic ACTION_STATUS  = 1'b0;
  localparam logic ACTION_ADD_BUF = 1'b1;

  localparam logic [15:0] THRESHOLD_RESET = 16'd64;

  typedef struct packed {
    logic [ID_BITS-1:0] id;
    logic [15:0]        bytes;
  } entry_t;

  typedef struct packed {
    logic push;
    logic pop;
  } cell_ctrl_t;

endpackage

@@ design/rx_block_reassembly.sv @@
// Receive reassembly controller: one transaction accepted per cycle when the output can move.
// A registered result appears on the master side in the cycle after its input is accepted.
// Throughput: one transaction per cycle unless the output stalls; the head/packet update is
// registered on accept; the free stack is a row of shifting cells, one shift per push or pop.
// Reset: pool empty, no packet open, start threshold 64, output empty.
// Depends on rxbr_pkg, rxbr_stack_cell and rx_block_reassembly_assert.svh.
`include "rx_block_reassembly_assert.svh"

module rx_block_reassembly (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_wr_en_i,
  input  logic [15:0] cfg_wr_data_i,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // bytes_so_far[15:0], block_bytes[23:16], end_reason[26:24],
  // new_buffer_id[34:27], new_buffer_bytes[50:35], zero fill
  input  logic [55:0] s_axis_tdata_i,
  // action[0]
  input  logic [0:0]  s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // copy_block[0], copy_buffer[8:1], copy_offset[24:9], block_words[31:25],
  // deliver[32], deliver_buffer[40:33], deliver_length[56:41],
  // buffer_rejected[57], zero fill
  output logic [63:0] m_axis_tdata_o
);

  localparam int N  = rxbr_pkg::STACK_DEPTH;
  localparam int IB = rxbr_pkg::ID_BITS;

  logic [15:0] so_far, thr_q;
  logic [7:0]  blk;
  logic [2:0]  reason;
  logic        action, accept;
  rxbr_pkg::entry_t new_entry;

  assign so_far          = s_axis_tdata_i[15:0];
  assign blk             = s_axis_tdata_i[23:16];
  assign reason          = s_axis_tdata_i[26:24];
  assign new_entry.id    = IB'(s_axis_tdata_i[34:27]);
  assign new_entry.bytes = s_axis_tdata_i[50:35];
  assign action          = s_axis_tuser_i[0];

  assign s_axis_tready_o = !m_axis_tvalid_o || m_axis_tready_i;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  logic                      head_valid_d, head_valid_q, in_packet_d, in_packet_q;
  rxbr_pkg::entry_t          head_d, head_q;
  logic [rxbr_pkg::CNT_W-1:0] cnt_d, cnt_q;
  logic [16:0]               br_d, br_q;
  rxbr_pkg::cell_ctrl_t      cell_ctrl;
  rxbr_pkg::entry_t          cell_q [N];

  // Free stack: cell 0 is the top.
  for (genvar g = 0; g < N; g++) begin : g_cell
    rxbr_pkg::entry_t push_src, pop_src;
    if (g == 0) begin : g_top
      assign push_src = new_entry;
    end else begin : g_mid
      assign push_src = cell_q[g-1];
    end
    if (g == N - 1) begin : g_bot
      assign pop_src = cell_q[g];
    end else begin : g_up
      assign pop_src = cell_q[g+1];
    end
    rxbr_stack_cell u_cell (
      .clk_i,
      .rst_ni,
      .ctrl_i      (cell_ctrl),
      .push_entry_i(push_src),
      .pop_entry_i (pop_src),
      .entry_o     (cell_q[g])
    );
  end

  logic        copy, dlv, rej, ip, start;
  logic [IB-1:0] cbuf, dbuf;
  logic [15:0] coff, dlen;
  logic [6:0]  words;
  logic [8:0]  words_sum;
  logic [16:0] sum;

  assign words_sum = {1'b0, blk} + 9'd3;
  assign sum       = br_q + {9'd0, blk};

  always_comb begin
    head_valid_d = head_valid_q;
    head_d       = head_q;
    cnt_d        = cnt_q;
    br_d         = br_q;
    in_packet_d  = in_packet_q;
    cell_ctrl    = '0;
    copy = 1'b0; cbuf = '0; coff = '0; words = '0;
    dlv  = 1'b0; dbuf = '0; dlen = '0; rej = 1'b0;
    ip    = in_packet_q && head_valid_q;
    start = so_far <= thr_q;
    if (action == rxbr_pkg::ACTION_ADD_BUF) begin
      if (!head_valid_q) begin
        head_d       = new_entry;
        head_valid_d = 1'b1;
      end else if (cnt_q < rxbr_pkg::DEPTH_CNT) begin
        cell_ctrl.push = accept;
        cnt_d          = cnt_q + 1'b1;
      end else begin
        rej = 1'b1;
      end
    end else begin
      words = words_sum[8:2];
      if (start) begin
        if (ip || head_valid_q) begin
          ip   = 1'b1;
          copy = 1'b1;
          cbuf = head_q.id;
          br_d = {1'b0, so_far};
        end
      end else if (ip) begin
        br_d = sum;
        if (sum > {1'b0, head_q.bytes}) begin
          ip = 1'b0;
        end else begin
          copy = 1'b1;
          cbuf = head_q.id;
          coff = br_q[15:0];
        end
      end
      if (reason == rxbr_pkg::REASON_FCS_OK) begin
        if (ip) begin
          dlv  = 1'b1;
          dbuf = head_q.id;
          dlen = br_d[15:0];
          if (cnt_q != '0) begin
            cell_ctrl.pop = accept;
            cnt_d         = cnt_q - 1'b1;
            head_d        = cell_q[0];
          end else begin
            head_valid_d = 1'b0;
            head_d       = '0;
          end
          ip = 1'b0;
        end
      end else if (reason == rxbr_pkg::REASON_FCS_BAD || reason == rxbr_pkg::REASON_ODD_NYB ||
                   reason == rxbr_pkg::REASON_OVERRUN || reason == rxbr_pkg::REASON_FRAMING) begin
        ip = 1'b0;
      end
      in_packet_d = ip;
    end
  end

  logic        out_valid_q;
  logic [63:0] out_data_d, out_data_q;

  assign out_data_d = {6'd0, rej, dlen, 8'(dbuf), dlv, words, coff, 8'(cbuf), copy};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q        <= rxbr_pkg::THRESHOLD_RESET;
      head_valid_q <= 1'b0;
      head_q       <= '0;
      cnt_q        <= '0;
      in_packet_q  <= 1'b0;
      br_q         <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_wr_en_i) begin
        thr_q <= cfg_wr_data_i;
      end
      if (accept) begin
        head_valid_q <= head_valid_d;
        head_q       <= head_d;
        cnt_q        <= cnt_d;
        in_packet_q  <= in_packet_d;
        br_q         <= br_d;
        out_valid_q  <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  `RXBR_ASSERT_SAME(a_cnt_range, 1'b1, cnt_q <= rxbr_pkg::DEPTH_CNT, "free count above depth")
  `RXBR_ASSERT_SAME(a_stack_head, cnt_q != '0, head_valid_q, "stacked buffers without head")
  `RXBR_ASSERT_SAME(a_pkt_head, in_packet_q, head_valid_q, "packet open without head buffer")
  `RXBR_ASSERT_NEXT(a_out_load, accept, m_axis_tvalid_o, "accepted transaction lost")

endmodule

@@ design/rxbr_stack_cell.sv @@
// One cell of the free-buffer stack: holds one entry, shifts down on push, up on pop.
// Depends on rxbr_pkg.
module rxbr_stack_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rxbr_pkg::cell_ctrl_t ctrl_i,
  input  rxbr_pkg::entry_t    push_entry_i,
  input  rxbr_pkg::entry_t    pop_entry_i,
  output rxbr_pkg::entry_t    entry_o
);

  rxbr_pkg::entry_t entry_d, entry_q;

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.push) begin
      entry_d = push_entry_i;
    end else if (ctrl_i.pop) begin
      entry_d = pop_entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= '0;
    end else begin
      entry_q <= entry_d;
    end
  end

  assign entry_o = entry_q;

endmodule

@@ test/rxbr_reassembly_checker.sv @@
// Scoreboard for rx_block_reassembly: tracks the buffer pool and packet state
// from observed transactions and compares each result word field by field.
// Depends on rxbr_pkg.
module rxbr_reassembly_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_wr_en_i,
  input  logic [15:0] cfg_wr_data_i,
  input  logic        s_axis_tvalid_i,
  input  logic        s_axis_tready_i,
  input  logic [55:0] s_axis_tdata_i,
  input  logic [0:0]  s_axis_tuser_i,
  input  logic        m_axis_tvalid_i,
  input  logic        m_axis_tready_i,
  input  logic [63:0] m_axis_tdata_i,
  output int          pending_o,
  output int          failures_o
);

  typedef struct packed {
    logic        rejected;
    logic [15:0] dlv_length;
    logic [7:0]  dlv_buffer;
    logic        dlv;
    logic [6:0]  words;
    logic [15:0] offset;
    logic [7:0]  dest;
    logic        copy;
  } block_plan_t;

  logic [15:0]      start_threshold;
  logic             head_valid;
  rxbr_pkg::entry_t head;
  rxbr_pkg::entry_t free_stack [rxbr_pkg::STACK_DEPTH];
  int unsigned      free_used;
  logic             in_pkt;
  logic [16:0]      rx_bytes;

  block_plan_t expected_plans[$];
  block_plan_t want;
  block_plan_t got;
  int          failures = 0;

  initial begin
    pending_o  = 0;
    failures_o = 0;
  end

  function automatic block_plan_t plan_transaction(input logic act, input logic [55:0] d);
    block_plan_t      p;
    logic [15:0]      so_far;
    logic [7:0]       blk;
    logic [2:0]       reason;
    rxbr_pkg::entry_t e;
    logic [16:0]      sum;
    p       = '0;
    so_far  = d[15:0];
    blk     = d[23:16];
    reason  = d[26:24];
    e.id    = d[34:27];
    e.bytes = d[50:35];
    if (act == rxbr_pkg::ACTION_ADD_BUF) begin
      if (!head_valid) begin
        head       = e;
        head_valid = 1'b1;
      end else if (free_used < rxbr_pkg::STACK_DEPTH) begin
        free_stack[free_used] = e;
        free_used++;
      end else begin
        p.rejected = 1'b1;
      end
      return p;
    end
    p.words = 7'((blk + 9'd3) >> 2);
    if (in_pkt && !head_valid) in_pkt = 1'b0;
    if (so_far <= start_threshold) begin
      if (in_pkt || head_valid) begin
        in_pkt   = 1'b1;
        p.copy   = 1'b1;
        p.dest   = head.id;
        rx_bytes = {1'b0, so_far};
      end
    end else if (in_pkt) begin
      sum      = rx_bytes + blk;
      p.offset = rx_bytes[15:0];
      rx_bytes = sum;
      if (sum > {1'b0, head.bytes}) begin
        in_pkt   = 1'b0;
        p.offset = '0;
      end else begin
        p.copy = 1'b1;
        p.dest = head.id;
      end
    end
    if (reason == rxbr_pkg::REASON_FCS_OK) begin
      if (in_pkt) begin
        p.dlv        = 1'b1;
        p.dlv_buffer = head.id;
        p.dlv_length = rx_bytes[15:0];
        if (free_used > 0) begin
          free_used--;
          head = free_stack[free_used];
        end else begin
          head_valid = 1'b0;
          head       = '0;
        end
        in_pkt = 1'b0;
      end
    end else if (reason inside {rxbr_pkg::REASON_FCS_BAD, rxbr_pkg::REASON_ODD_NYB,
                                rxbr_pkg::REASON_OVERRUN, rxbr_pkg::REASON_FRAMING}) begin
      in_pkt = 1'b0;
    end
    return p;
  endfunction

  task automatic compare_field(input string name, input int unsigned exp_val,
                               input int unsigned act_val);
    if (exp_val != act_val) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, exp_val, act_val);
      failures++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_threshold = rxbr_pkg::THRESHOLD_RESET;
      head_valid      = 1'b0;
      head            = '0;
      free_used       = 0;
      in_pkt          = 1'b0;
      rx_bytes        = '0;
      expected_plans.delete();
      pending_o       <= 0;
    end else begin
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        got = m_axis_tdata_i[57:0];
        if (expected_plans.size() == 0) begin
          $display("%0t: unexpected result, expected none, got %h", $time, m_axis_tdata_i);
          failures++;
        end else begin
          want = expected_plans.pop_front();
          compare_field("copy_block", want.copy, got.copy);
          compare_field("copy_buffer", want.dest, got.dest);
          compare_field("copy_offset", want.offset, got.offset);
          compare_field("block_words", want.words, got.words);
          compare_field("deliver", want.dlv, got.dlv);
          compare_field("deliver_buffer", want.dlv_buffer, got.dlv_buffer);
          compare_field("deliver_length", want.dlv_length, got.dlv_length);
          compare_field("buffer_rejected", want.rejected, got.rejected);
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        expected_plans.push_back(plan_transaction(s_axis_tuser_i[0], s_axis_tdata_i));
      end
      if (cfg_wr_en_i) start_threshold = cfg_wr_data_i;
      pending_o  <= expected_plans.size();
      failures_o <= failures;
    end
  end

endmodule

@@ test/testbench.sv @@
// Top of the rx_block_reassembly bench: clock, reset, stimulus and verdict.
// Drives buffer adds and status words, directed then packet-shaped random traffic.
// Depends on rxbr_pkg, rx_block_reassembly and rxbr_reassembly_checker.
module testbench;

  localparam logic [2:0] REASON_BLOCK   = 3'd3;
  localparam logic [2:0] REASON_SPARE_6 = 3'd6;
  localparam logic [2:0] REASON_SPARE_7 = 3'd7;
  localparam int         PHASE_ITEMS    = 305;
  localparam int         HOLD_CYCLES    = 300;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        cfg_wr_en   = 1'b0;
  logic [15:0] cfg_wr_data = '0;
  logic        s_tvalid    = 1'b0;
  logic [55:0] s_tdata     = '0;
  logic [0:0]  s_tuser     = '0;
  logic        m_tready    = 1'b0;
  logic        s_tready;
  logic        m_tvalid;
  logic [63:0] m_tdata;
  int          pending;
  int          failures;

  logic [15:0] threshold_now = rxbr_pkg::THRESHOLD_RESET;
  bit          quiet         = 1'b0;
  int          hold_asked    = 0;
  int          hold_done     = 0;
  int          sent          = 0;

  always #4 clk_i = ~clk_i;

  rx_block_reassembly u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_wr_en_i     (cfg_wr_en),
    .cfg_wr_data_i   (cfg_wr_data),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata)
  );

  rxbr_reassembly_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_wr_en_i     (cfg_wr_en),
    .cfg_wr_data_i   (cfg_wr_data),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_i (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_i (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_i  (m_tdata),
    .pending_o       (pending),
    .failures_o      (failures)
  );

  task automatic maybe_idle();
    if (!quiet && $urandom_range(0, 4) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  endtask

  task automatic send_item(input logic act, input logic [15:0] so_far, input logic [7:0] blk,
                           input logic [2:0] reason, input logic [7:0] id,
                           input logic [15:0] cap);
    s_tvalid <= 1'b1;
    s_tuser  <= act;
    s_tdata  <= {5'b0, cap, id, reason, blk, so_far};
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
    sent++;
    maybe_idle();
  endtask

  task automatic send_status(input logic [15:0] so_far, input logic [7:0] blk,
                             input logic [2:0] reason);
    send_item(rxbr_pkg::ACTION_STATUS, so_far, blk, reason, 8'($urandom), 16'($urandom));
  endtask

  task automatic add_buffer(input logic [7:0] id, input logic [15:0] cap);
    send_item(rxbr_pkg::ACTION_ADD_BUF, 16'($urandom), 8'($urandom), 3'($urandom), id, cap);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic set_threshold(input logic [15:0] value);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk_i);
    cfg_wr_en     <= 1'b0;
    threshold_now = value;
  endtask

  function automatic logic [15:0] start_bytes();
    if ($urandom_range(0, 3) != 0 && threshold_now > 16'd64)
      return 16'($urandom_range(0, 64));
    return 16'($urandom_range(0, threshold_now));
  endfunction

  function automatic logic [15:0] later_bytes();
    if (threshold_now == 16'hffff) return 16'($urandom);
    return 16'($urandom_range(threshold_now + 1, 65535));
  endfunction

  task automatic add_random_buffer();
    int pick;
    pick = $urandom_range(0, 7);
    if (pick == 0) add_buffer(8'($urandom), 16'($urandom));
    else if (pick == 1) add_buffer(8'($urandom), 16'($urandom_range(0, 300)));
    else add_buffer(8'($urandom), 16'($urandom_range(400, 2500)));
  endtask

  task automatic send_packet();
    int          pick;
    logic [2:0]  fin;
    pick = $urandom_range(0, 9);
    send_status(start_bytes(), 8'($urandom),
                pick == 0 ? REASON_SPARE_6 :
                (pick == 1 ? rxbr_pkg::REASON_FCS_OK : REASON_BLOCK));
    repeat ($urandom_range(0, 6)) begin
      pick = $urandom_range(0, 9);
      send_status(later_bytes(), 8'($urandom),
                  pick == 0 ? REASON_SPARE_7 : REASON_BLOCK);
    end
    pick = $urandom_range(0, 9);
    case (pick)
      6:       fin = rxbr_pkg::REASON_FCS_BAD;
      7:       fin = rxbr_pkg::REASON_ODD_NYB;
      8:       fin = rxbr_pkg::REASON_OVERRUN;
      9:       fin = rxbr_pkg::REASON_FRAMING;
      default: fin = rxbr_pkg::REASON_FCS_OK;
    endcase
    send_status(later_bytes(), 8'($urandom), fin);
  endtask

  task automatic run_traffic(input int target);
    int pick;
    while (sent < target) begin
      pick = $urandom_range(0, 15);
      if (pick < 2) begin
        add_random_buffer();
      end else if (pick == 2) begin
        send_status(16'($urandom), 8'($urandom), 3'($urandom));
      end else begin
        send_packet();
        if ($urandom_range(0, 3) != 0) add_random_buffer();
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  initial begin
    wait (rst_ni);
    forever begin
      if (hold_asked != hold_done) begin
        hold_done++;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end else begin
        m_tready <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk_i);
      end
    end
  end

  initial begin
    #4_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    logic [15:0] levels [6];
    levels = '{16'd0, 16'hffff, 16'd1500, 16'($urandom), rxbr_pkg::THRESHOLD_RESET, 16'd200};
    wait (rst_ni);
    @(posedge clk_i);

    send_status(16'd0, 8'd255, rxbr_pkg::REASON_FCS_OK);
    send_status(16'hffff, 8'd0, REASON_BLOCK);
    add_buffer(8'hff, 16'hffff);
    add_buffer(8'h00, 16'h0000);
    add_buffer(8'ha5, 16'd100);
    send_status(rxbr_pkg::THRESHOLD_RESET, 8'd4, REASON_BLOCK);
    send_status(rxbr_pkg::THRESHOLD_RESET + 16'd1, 8'd255, REASON_SPARE_6);
    send_status(16'd10, 8'd1, REASON_SPARE_7);
    send_status(16'd1000, 8'd200, rxbr_pkg::REASON_FCS_OK);
    send_status(16'd0, 8'd8, REASON_BLOCK);
    send_status(16'd500, 8'd101, REASON_BLOCK);
    send_status(16'd500, 8'd3, rxbr_pkg::REASON_FCS_OK);
    send_status(16'd50, 8'd50, rxbr_pkg::REASON_FCS_BAD);
    send_status(16'd1, 8'd2, rxbr_pkg::REASON_ODD_NYB);
    send_status(16'd2, 8'd3, rxbr_pkg::REASON_OVERRUN);
    send_status(16'd3, 8'd5, rxbr_pkg::REASON_FRAMING);
    send_status(16'd20, 8'd0, rxbr_pkg::REASON_FCS_OK);
    send_status(16'd0, 8'd0, REASON_BLOCK);
    send_status(16'd65, 8'd0, REASON_BLOCK);
    send_status(16'd40, 8'd1, rxbr_pkg::REASON_FCS_OK);
    send_status(16'd0, 8'd7, rxbr_pkg::REASON_FCS_OK);
    add_buffer(8'h5a, 16'd300);

    for (int i = 0; i < 6; i++) begin
      set_threshold(levels[i]);
      if (i == 2) repeat (20) add_random_buffer();
      if (i == 3) hold_asked++;
      if (i == 5) quiet = 1'b1;
      run_traffic(sent + PHASE_ITEMS);
    end

    drain();
    repeat (10) @(posedge clk_i);
    if (failures == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

@@ rx_block_reassembly.f @@
+incdir+design
design/rxbr_pkg.sv
design/rxbr_stack_cell.sv
design/rx_block_reassembly.sv
test/rxbr_reassembly_checker.sv
test/testbench.sv
